/* src/rpnsc_pkg.sv */
// ----------------------------------------------------------------------------
// rpnsc_pkg: shared types and constants for the rpn stack calculator
// opcodes, controller states, and the command/status bundles between modules
// ----------------------------------------------------------------------------
`default_nettype none

package rpnsc_pkg;

  // default number of stack entries
  localparam int unsigned STACK_DEPTH_DEF = 16;

  // field widths
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned DEPTH_W     = 5;
  localparam int unsigned OPCODE_W    = 2;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 40;

  // operation codes
  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2,
    OP_MUL  = 2'd3
  } opcode_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_COMMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic rd_en;
    logic exec;
    logic commit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_valid;
  } status_t;

endpackage

`default_nettype wire

/* src/rpn_stack_calculator_core.sv */
// ----------------------------------------------------------------------------
// rpn_stack_calculator_core: reverse polish integer calculator on a fixed stack
// push goes from the accepted beat straight to commit; add/sub/mul pass the
// read and execute states first; one beat in flight, the next is taken after commit
// a result still held by m_tready stalls the commit and so the next input beat
// reset clears stack pointer and output valid; stack memory is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_calculator_core #(
  parameter int unsigned STACK_DEPTH = rpnsc_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // slave side
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [rpnsc_pkg::IN_TDATA_W-1:0]     s_tdata,  // operand_value[31:0]
  input  wire logic [rpnsc_pkg::OPCODE_W-1:0]       s_tuser,  // opcode[1:0]
  // master side
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // top_value[31:0], depth[36:32], underflow[37], overflow[38], bit 39 tied to 0
  output logic [rpnsc_pkg::OUT_TDATA_W-1:0]         m_tdata
);

  rpnsc_pkg::cmd_t    cmd;
  rpnsc_pkg::status_t status;

  // sequencer
  rpnsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_opcode (s_tuser),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // stack and alu
  rpnsc_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_opcode  (s_tuser),
    .in_operand (s_tdata),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_data   (m_tdata)
  );

endmodule

`default_nettype wire

/* src/rpnsc_ctrl.sv */
// ----------------------------------------------------------------------------
// rpnsc_ctrl: operation sequencer
// takes one beat; push goes straight to commit, arithmetic steps through read and execute, then commits
// ----------------------------------------------------------------------------
`default_nettype none

module rpnsc_ctrl (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [rpnsc_pkg::OPCODE_W-1:0]       in_opcode,
  input  wire logic                                 out_ready,
  input  wire rpnsc_pkg::status_t                   status,
  output rpnsc_pkg::cmd_t                           cmd
);

  rpnsc_pkg::state_t state;
  rpnsc_pkg::state_t state_next;
  logic              accept;
  logic              out_free;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpnsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    in_ready    = (state == rpnsc_pkg::ST_IDLE);
    accept      = in_valid && in_ready;
    out_free    = !status.out_valid || out_ready;
    cmd         = '0;
    cmd.load_in = accept;
    state_next  = state;
    case (state)
      rpnsc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_opcode == rpnsc_pkg::OP_PUSH) begin
            state_next = rpnsc_pkg::ST_COMMIT;
          end else begin
            state_next = rpnsc_pkg::ST_READ;
          end
        end
      end
      rpnsc_pkg::ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = rpnsc_pkg::ST_EXEC;
      end
      rpnsc_pkg::ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = rpnsc_pkg::ST_COMMIT;
      end
      rpnsc_pkg::ST_COMMIT: begin
        // hold until the output register can take the result
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = rpnsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rpnsc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/rpnsc_dp.sv */
// ----------------------------------------------------------------------------
// rpnsc_dp: stack datapath
// top of stack in a register, lower entries in a memory, alu and result register
// ----------------------------------------------------------------------------
`default_nettype none

module rpnsc_dp #(
  parameter int unsigned STACK_DEPTH = rpnsc_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire rpnsc_pkg::cmd_t                       cmd,
  output rpnsc_pkg::status_t                         status,
  input  wire logic [rpnsc_pkg::OPCODE_W-1:0]        in_opcode,
  input  wire logic [rpnsc_pkg::VALUE_W-1:0]         in_operand,
  input  wire logic                                  out_ready,
  output logic                                       out_valid,
  output logic [rpnsc_pkg::OUT_TDATA_W-1:0]          out_data
);

  localparam int unsigned SpW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned VW    = rpnsc_pkg::VALUE_W;
  localparam int unsigned DW    = rpnsc_pkg::DEPTH_W;

  rpnsc_pkg::opcode_t op_reg;
  logic [VW-1:0]      val_reg;
  logic [VW-1:0]      stack_store [STACK_DEPTH];
  logic [VW-1:0]      tos;
  logic [VW-1:0]      tos_next;
  logic [SpW-1:0]     sp;
  logic [SpW-1:0]     sp_next;
  logic [SpW-1:0]     sp_m1;
  logic [SpW-1:0]     sp_m2;
  logic [VW-1:0]      rd_data;
  logic [VW-1:0]      alu_res;
  logic [VW-1:0]      a_op;
  logic [VW-1:0]      b_op;
  logic               sp_nz;
  logic               sp_ge2;
  logic               full;
  logic               wr_en;
  logic               under_next;
  logic               over_next;
  logic [VW-1:0]      top_out;
  logic [SpW+DW-1:0]  sp_ext;

  // pointer arithmetic
  assign sp_nz  = (sp != '0);
  assign sp_ge2 = (sp >= SpW'(2));
  assign full   = (sp == SpW'(STACK_DEPTH));
  assign sp_m1  = sp - SpW'(1);
  assign sp_m2  = sp - SpW'(2);

  // latch the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_reg  <= rpnsc_pkg::opcode_t'(in_opcode);
      val_reg <= in_operand;
    end
  end

  // stack memory: second entry read, old top written back on push
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      stack_store[sp_m1[AddrW-1:0]] <= tos;
    end
    if (cmd.rd_en) begin
      rd_data <= stack_store[sp_m2[AddrW-1:0]];
    end
  end

  // missing operands read as zero
  assign a_op = sp_ge2 ? rd_data : '0;
  assign b_op = sp_nz ? tos : '0;

  // alu with registered result
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      case (op_reg)
        rpnsc_pkg::OP_ADD: alu_res <= a_op + b_op;
        rpnsc_pkg::OP_SUB: alu_res <= a_op - b_op;
        rpnsc_pkg::OP_MUL: alu_res <= a_op * b_op;
        default:           alu_res <= '0;
      endcase
    end
  end

  // stack update at commit
  always_comb begin
    tos_next   = tos;
    sp_next    = sp;
    under_next = 1'b0;
    over_next  = 1'b0;
    wr_en      = 1'b0;
    if (op_reg == rpnsc_pkg::OP_PUSH) begin
      if (full) begin
        over_next = 1'b1;
      end else begin
        wr_en    = sp_nz;
        tos_next = val_reg;
        sp_next  = sp + SpW'(1);
      end
    end else begin
      tos_next   = alu_res;
      under_next = !sp_ge2;
      sp_next    = sp_ge2 ? sp_m1 : SpW'(1);
    end
  end

  // result fields
  assign top_out = (sp_next != '0) ? tos_next : '0;
  assign sp_ext  = {{DW{1'b0}}, sp_next};

  // stack registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.commit) begin
      sp <= sp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      tos <= tos_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= {1'b0, over_next, under_next, sp_ext[DW-1:0], top_out};
    end
  end

  assign status.out_valid = out_valid;

`ifndef NO_ASSERTIONS
  // pointer never passes the stack size
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SpW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  // pointer moves only at commit
  a_sp_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(sp))
    else $error("stack pointer moved outside commit");

  // an arithmetic beat always leaves something on the stack
  a_arith_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && (op_reg != rpnsc_pkg::OP_PUSH) |=> (sp != '0) && out_valid)
    else $error("arithmetic left stack empty");

  // commit never overwrites a result still waiting
  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result overwritten");

  // one step cannot both underflow and overflow
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data[VW+DW] && out_data[VW+DW+1]))
    else $error("both flags raised");
`endif

endmodule

`default_nettype wire
